// ===== design/pimsc_pkg.sv =====
// shared types, constants and widths for the pi motor speed controller
package pimsc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int PWM_BITS  = 11;

    localparam int COUNT_W   = 32;
    localparam int SP_W      = 7;
    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 8;
    localparam int LIMIT_W   = 12;
    localparam int CFG_W     = 12;

    localparam int FILT_W    = SP_W + FRAC_BITS;
    localparam int FSUM_W    = FILT_W + 9;
    localparam int ERR_W     = SPEED_W + FRAC_BITS + 1;
    localparam int ISUM_W    = ERR_W + 1;
    localparam int INTEG_W   = LIMIT_W + FRAC_BITS + 1;
    localparam int CMD_W     = ERR_W + GAIN_W + 2;

    localparam logic [SP_W-1:0]   SETPOINT_MAX = SP_W'(100);
    localparam logic [FSUM_W-1:0] COEF_KEEP    = FSUM_W'(179);
    localparam logic [FSUM_W-1:0] COEF_NEW     = FSUM_W'(77);
    localparam logic [FSUM_W-1:0] COEF_ROUND   = FSUM_W'(128);

    localparam logic [GAIN_W-1:0]   RST_GAIN_PROP   = GAIN_W'(10);
    localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG  = GAIN_W'(15);
    localparam logic [LIMIT_W-1:0]  RST_INTEG_LIMIT = LIMIT_W'(150);
    localparam logic [PWM_BITS-1:0] RST_OUT_MAX     = PWM_BITS'(2000);

    typedef enum logic [1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_INTEG_LIM  = 2'd2,
        REG_OUT_MAX    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] encoder_count;
        logic [SP_W-1:0]           setpoint;
        logic                      motor_enable;
        logic                      forward;
    } pimsc_in_t;

    typedef struct packed {
        logic [PWM_BITS-1:0] pwm_duty;
        logic                drive_on;
        logic                direction_pin;
        logic [SPEED_W-1:0]  measured_speed;
        logic                reversing;
    } pimsc_out_t;

    typedef struct packed {
        logic                      active;
        logic                      direction_pin;
        logic                      reversing;
        logic [SPEED_W-1:0]        measured_speed;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
    } pimsc_stage_t;

endpackage

// ===== design/pimsc_state_calc.sv =====
// speed measurement, setpoint filter and clamped integrator update for one tick
module pimsc_state_calc (
    input  pimsc_pkg::pimsc_in_t                  item,
    input  logic signed [pimsc_pkg::COUNT_W-1:0]  prev_count,
    input  logic signed [pimsc_pkg::INTEG_W-1:0]  integ,
    input  logic [pimsc_pkg::FILT_W-1:0]          filt,
    input  logic                                  cur_dir,
    input  logic [pimsc_pkg::LIMIT_W-1:0]         integ_limit,
    output logic signed [pimsc_pkg::COUNT_W-1:0]  prev_count_next,
    output logic signed [pimsc_pkg::INTEG_W-1:0]  integ_next,
    output logic [pimsc_pkg::FILT_W-1:0]          filt_next,
    output logic                                  cur_dir_next,
    output pimsc_pkg::pimsc_stage_t               stage
);
    import pimsc_pkg::*;

    logic [SP_W-1:0]           sp_sat;
    logic signed [COUNT_W:0]   diff;
    logic [COUNT_W:0]          mag;
    logic [SPEED_W-1:0]        speed;
    logic [FSUM_W-1:0]         target;
    logic [FSUM_W-1:0]         filt_sum;
    logic [FILT_W-1:0]         filt_new;
    logic signed [ERR_W-1:0]   err;
    logic signed [ISUM_W-1:0]  integ_sum;
    logic signed [ISUM_W-1:0]  lim;
    logic signed [ISUM_W-1:0]  integ_clamped;
    logic                      reverse;
    logic                      run;

    assign sp_sat = (item.setpoint > SETPOINT_MAX) ? SETPOINT_MAX : item.setpoint;

    assign diff = $signed({item.encoder_count[COUNT_W-1], item.encoder_count})
                - $signed({prev_count[COUNT_W-1], prev_count});
    assign mag  = diff[COUNT_W] ? (COUNT_W+1)'(-diff) : diff;
    assign speed = (|mag[COUNT_W:SPEED_W]) ? {SPEED_W{1'b1}} : mag[SPEED_W-1:0];

    // low-pass: 179/256 of the old value plus 77/256 of the target, rounded half up
    assign target   = FSUM_W'({sp_sat, {FRAC_BITS{1'b0}}});
    assign filt_sum = COEF_KEEP * FSUM_W'(filt) + COEF_NEW * target + COEF_ROUND;
    assign filt_new = filt_sum[FILT_W+7:8];

    assign err = $signed({{(ERR_W-FILT_W){1'b0}}, filt_new})
               - $signed({1'b0, speed, {FRAC_BITS{1'b0}}});

    assign integ_sum = ISUM_W'(integ) + ISUM_W'(err);
    assign lim       = $signed(ISUM_W'({integ_limit, {FRAC_BITS{1'b0}}}));

    always_comb begin
        priority if (integ_sum > lim) begin
            integ_clamped = lim;
        end else if (integ_sum < -lim) begin
            integ_clamped = -lim;
        end else begin
            integ_clamped = integ_sum;
        end
    end

    assign reverse = (item.forward != cur_dir);
    assign run     = !reverse && item.motor_enable && (sp_sat != '0);

    assign prev_count_next = item.encoder_count;
    assign cur_dir_next    = item.forward;
    assign filt_next       = run ? filt_new : '0;
    assign integ_next      = run ? integ_clamped[INTEG_W-1:0] : '0;

    always_comb begin
        stage.active         = run;
        stage.direction_pin  = !item.forward;
        stage.reversing      = reverse;
        stage.measured_speed = reverse ? '0 : speed;
        stage.err            = err;
        stage.integ          = integ_clamped[INTEG_W-1:0];
    end

endmodule

// ===== design/pimsc_duty_calc.sv =====
// pi command from registered error and integrator, clamped to the duty range
module pimsc_duty_calc (
    input  pimsc_pkg::pimsc_stage_t          stage,
    input  logic [pimsc_pkg::GAIN_W-1:0]     gain_prop,
    input  logic [pimsc_pkg::GAIN_W-1:0]     gain_integ,
    input  logic [pimsc_pkg::PWM_BITS-1:0]   out_max,
    output pimsc_pkg::pimsc_out_t            result
);
    import pimsc_pkg::*;

    logic signed [CMD_W-1:0]            prod_p;
    logic signed [CMD_W-1:0]            prod_i;
    logic signed [CMD_W-1:0]            cmd;
    logic [CMD_W-2-FRAC_BITS:0]         cmd_int;
    logic [PWM_BITS-1:0]                duty;

    assign prod_p  = CMD_W'(stage.err) * CMD_W'($signed({1'b0, gain_prop}));
    assign prod_i  = CMD_W'(stage.integ) * CMD_W'($signed({1'b0, gain_integ}));
    assign cmd     = prod_p + prod_i;
    assign cmd_int = cmd[CMD_W-2:FRAC_BITS];

    always_comb begin
        priority if (!stage.active || cmd[CMD_W-1]) begin
            duty = '0;
        end else if (cmd_int > ($bits(cmd_int))'(out_max)) begin
            duty = out_max;
        end else begin
            duty = cmd_int[PWM_BITS-1:0];
        end
    end

    always_comb begin
        result.pwm_duty       = duty;
        result.drive_on       = stage.active;
        result.direction_pin  = stage.direction_pin;
        result.measured_speed = stage.measured_speed;
        result.reversing      = stage.reversing;
    end

endmodule

// ===== design/pi_motor_speed_controller.sv =====
// top level of the pi motor speed controller with anti-windup
//
//  channel   ports                                 carries
//  s_        s_valid  s_ready  s_data              one control tick
//  m_        m_valid  m_ready  m_data              duty, drive, direction, speed
//  cfg_      cfg_wr_en  cfg_index  cfg_wdata       gains and limits, no wait
//
// one tick per clock unless the output stalls; ticks pass stage_reg, then result_reg
// the loop state (count, filter, integrator, direction) updates at the input transfer,
// the pi multiply sits in the second stage before the result register
// reset clears both stage valids, the loop state and the registers to defaults
// a stalled result holds both stages; input ready drops only when both are full
module pi_motor_speed_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pimsc_pkg::pimsc_in_t                 s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pimsc_pkg::pimsc_out_t                m_data,
    input  logic                                 cfg_wr_en,
    input  pimsc_pkg::cfg_index_t                cfg_index,
    input  logic [pimsc_pkg::CFG_W-1:0]          cfg_wdata
);
    import pimsc_pkg::*;

    logic [GAIN_W-1:0]          gain_prop_reg;
    logic [GAIN_W-1:0]          gain_integ_reg;
    logic [LIMIT_W-1:0]         integ_limit_reg;
    logic [PWM_BITS-1:0]        out_max_reg;

    logic signed [COUNT_W-1:0]  prev_count_reg;
    logic signed [COUNT_W-1:0]  prev_count_next;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    logic [FILT_W-1:0]          filt_reg;
    logic [FILT_W-1:0]          filt_next;
    logic                       cur_dir_reg;
    logic                       cur_dir_next;

    pimsc_stage_t               stage_next;
    pimsc_stage_t               stage_reg;
    logic                       stage_valid_reg;
    pimsc_out_t                 result_next;
    pimsc_out_t                 result_reg;
    logic                       result_valid_reg;

    logic                       out_free;
    logic                       stage_ready;
    logic                       s_xfer;

    assign out_free    = !result_valid_reg || m_ready;
    assign stage_ready = !stage_valid_reg || out_free;
    assign s_ready     = stage_ready;
    assign s_xfer      = s_valid && stage_ready;
    assign m_valid     = result_valid_reg;
    assign m_data      = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg   <= RST_GAIN_PROP;
            gain_integ_reg  <= RST_GAIN_INTEG;
            integ_limit_reg <= RST_INTEG_LIMIT;
            out_max_reg     <= RST_OUT_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_PROP:  gain_prop_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_INTEG: gain_integ_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_LIM:  integ_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_OUT_MAX:    out_max_reg     <= cfg_wdata[PWM_BITS-1:0];
                default: ;
            endcase
        end
    end

    pimsc_state_calc u_state_calc (
        .item            (s_data),
        .prev_count      (prev_count_reg),
        .integ           (integ_reg),
        .filt            (filt_reg),
        .cur_dir         (cur_dir_reg),
        .integ_limit     (integ_limit_reg),
        .prev_count_next (prev_count_next),
        .integ_next      (integ_next),
        .filt_next       (filt_next),
        .cur_dir_next    (cur_dir_next),
        .stage           (stage_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
            integ_reg      <= '0;
            filt_reg       <= '0;
            cur_dir_reg    <= 1'b1;
        end else if (s_xfer) begin
            prev_count_reg <= prev_count_next;
            integ_reg      <= integ_next;
            filt_reg       <= filt_next;
            cur_dir_reg    <= cur_dir_next;
        end
    end

    pimsc_duty_calc u_duty_calc (
        .stage      (stage_reg),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .out_max    (out_max_reg),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            if (stage_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (out_free) begin
                result_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            stage_reg <= stage_next;
        end
        if (out_free && stage_valid_reg) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== verif/pimsc_checker.sv =====
// checker for the pi motor speed controller: predicts each tick result and compares it
`timescale 1ns / 100ps
module pimsc_checker
    import pimsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  pimsc_in_t  s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  pimsc_out_t m_data,
    input  logic       cfg_wr_en,
    input  cfg_index_t cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int         fail_count,
    output int         results_pending
);

    localparam longint KEEP_WEIGHT = 179;
    localparam longint NEW_WEIGHT  = 77;
    localparam longint HALF_LSB    = 128;
    localparam longint SPEED_SAT   = 65535;
    localparam longint DUTY_TOP    = (longint'(1) << PWM_BITS) - 1;

    longint kp, ki, integ_bound, duty_cap;
    longint last_count, integ_acc, filt_sp;
    logic   dir_fwd;

    pimsc_out_t tick_results_q[$];
    int reported;

    function automatic pimsc_out_t regulate_tick(input pimsc_in_t t);
        pimsc_out_t r;
        longint cnt, sp, diff, speed, err, cmd, duty, lim;
        logic drive, rev;
        cnt   = longint'($signed(t.encoder_count));
        sp    = (t.setpoint > SETPOINT_MAX) ? longint'(SETPOINT_MAX) : longint'(t.setpoint);
        duty  = 0;
        drive = 1'b0;
        rev   = 1'b0;
        speed = 0;
        if (t.forward != dir_fwd) begin
            rev        = 1'b1;
            integ_acc  = 0;
            filt_sp    = 0;
            last_count = cnt;
            dir_fwd    = t.forward;
        end else begin
            diff = cnt - last_count;
            if (diff < 0) diff = -diff;
            speed = (diff > SPEED_SAT) ? SPEED_SAT : diff;
            last_count = cnt;
            if (!t.motor_enable || sp == 0) begin
                integ_acc = 0;
                filt_sp   = 0;
            end else begin
                lim     = integ_bound <<< FRAC_BITS;
                filt_sp = (KEEP_WEIGHT * filt_sp + NEW_WEIGHT * (sp <<< FRAC_BITS)
                           + HALF_LSB) >>> 8;
                err       = filt_sp - (speed <<< FRAC_BITS);
                integ_acc = integ_acc + err;
                if (integ_acc > lim) integ_acc = lim;
                if (integ_acc < -lim) integ_acc = -lim;
                cmd = err * kp + integ_acc * ki;
                if (cmd >= 0) begin
                    duty = cmd >>> FRAC_BITS;
                    if (duty > duty_cap) duty = duty_cap;
                    if (duty > DUTY_TOP) duty = DUTY_TOP;
                end
                drive = 1'b1;
            end
        end
        r.pwm_duty       = duty[PWM_BITS-1:0];
        r.drive_on       = drive;
        r.direction_pin  = ~dir_fwd;
        r.measured_speed = speed[SPEED_W-1:0];
        r.reversing      = rev;
        return r;
    endfunction

    task automatic check_field(input string fname, input longint expv, input longint actv);
        if (expv != actv) begin
            fail_count++;
            if (reported < 10) begin
                reported++;
                $display("pimsc_checker: %s mismatch at %0t: expected %0d, got %0d",
                         fname, $time, expv, actv);
            end
        end
    endtask

    initial begin
        fail_count      = 0;
        results_pending = 0;
        reported        = 0;
    end

    always @(posedge aclk) begin
        pimsc_out_t want;
        if (!aresetn) begin
            kp          = longint'(RST_GAIN_PROP);
            ki          = longint'(RST_GAIN_INTEG);
            integ_bound = longint'(RST_INTEG_LIMIT);
            duty_cap    = longint'(RST_OUT_MAX);
            last_count  = 0;
            integ_acc   = 0;
            filt_sp     = 0;
            dir_fwd     = 1'b1;
            tick_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAIN_PROP:  kp          = longint'(cfg_wdata[GAIN_W-1:0]);
                    REG_GAIN_INTEG: ki          = longint'(cfg_wdata[GAIN_W-1:0]);
                    REG_INTEG_LIM:  integ_bound = longint'(cfg_wdata[LIMIT_W-1:0]);
                    REG_OUT_MAX:    duty_cap    = longint'(cfg_wdata[PWM_BITS-1:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                tick_results_q.push_back(regulate_tick(s_data));
            if (m_valid && m_ready) begin
                if (tick_results_q.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display("pimsc_checker: unexpected result at %0t: %p", $time, m_data);
                    end
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("pwm_duty", want.pwm_duty, m_data.pwm_duty);
                    check_field("drive_on", want.drive_on, m_data.drive_on);
                    check_field("direction_pin", want.direction_pin, m_data.direction_pin);
                    check_field("measured_speed", want.measured_speed, m_data.measured_speed);
                    check_field("reversing", want.reversing, m_data.reversing);
                end
            end
        end
        results_pending = tick_results_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the pi motor speed controller: stimulus, config phases and verdict
`timescale 1ns / 100ps
module tb_top;
    import pimsc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_TICKS  = 200;
    localparam int SETTLE_TICKS = 6;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    pimsc_in_t        s_data;
    logic             m_valid;
    logic             m_ready;
    pimsc_out_t       m_data;
    logic             cfg_wr_en;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int fail_count;
    int results_pending;
    int cycle_count;

    logic signed [COUNT_W-1:0] cur_count;
    logic                      cur_fwd;
    int                        burst_left;
    int                        ticks_sent;

    pi_motor_speed_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pimsc_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver stall pattern
    initial begin
        int mode;
        int mode_left;
        mode_left = 0;
        mode      = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((mode_left % 16) < 4);
            endcase
        end
    end

    task automatic tick(input logic signed [COUNT_W-1:0] cnt, input logic [SP_W-1:0] sp,
                        input logic en, input logic fwd);
        pimsc_in_t t;
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        t.encoder_count = cnt;
        t.setpoint      = sp;
        t.motor_enable  = en;
        t.forward       = fwd;
        s_data  <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        cur_count = cnt;
        cur_fwd   = fwd;
        ticks_sent++;
    endtask

    task automatic drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (results_pending != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                                input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] omax);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GAIN_PROP;
        cfg_wdata <= kp;
        @(negedge aclk);
        cfg_index <= REG_GAIN_INTEG;
        cfg_wdata <= ki;
        @(negedge aclk);
        cfg_index <= REG_INTEG_LIM;
        cfg_wdata <= lim;
        @(negedge aclk);
        cfg_index <= REG_OUT_MAX;
        cfg_wdata <= omax;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic directed_ticks();
        tick(32'sd0, 7'd0, 1'b1, 1'b1);
        tick(32'sd50, 7'd100, 1'b1, 1'b1);
        tick(32'sd100, 7'd127, 1'b1, 1'b1);
        tick(32'sd100, 7'd1, 1'b1, 1'b1);
        tick(32'sd200, 7'd50, 1'b0, 1'b1);
        tick(-32'sd5, 7'd100, 1'b1, 1'b0);
        tick(-32'sd105, 7'd100, 1'b1, 1'b0);
        tick(32'sh7fffffff, 7'd100, 1'b1, 1'b0);
        tick(32'sh80000000, 7'd100, 1'b1, 1'b0);
        tick(32'sd0, 7'd0, 1'b0, 1'b1);
        repeat (6) tick(32'sd0, 7'd100, 1'b1, 1'b1);
        tick(32'sd70000, 7'd100, 1'b1, 1'b1);
        tick(32'sd135535, 7'd100, 1'b1, 1'b1);
        tick(32'sd135600, 7'd0, 1'b1, 1'b1);
        tick(32'sd135600, 7'd120, 1'b0, 1'b0);
        tick(32'sd135650, 7'd60, 1'b1, 1'b0);
        tick(32'sd135700, 7'd60, 1'b1, 1'b1);
    endtask

    task automatic run_segment();
        int kind;
        int len;
        int sp;
        int delta;
        logic en;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // regulated run in one direction
            if ($urandom_range(0, 3) == 0) cur_fwd = ~cur_fwd;
            sp  = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(1, 100);
            len = $urandom_range(4, 40);
            repeat (len) begin
                delta = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 300000)
                                                     : $urandom_range(0, 2 * sp + 4);
                en = ($urandom_range(0, 19) != 0);
                tick(cur_fwd ? cur_count + delta : cur_count - delta,
                     ($urandom_range(0, 29) == 0) ? 7'd0 : SP_W'(sp), en, cur_fwd);
            end
        end else if (kind < 85) begin
            len = $urandom_range(1, 10);
            repeat (len)
                tick($urandom, SP_W'($urandom_range(0, 127)), 1'($urandom), 1'($urandom));
        end else begin
            // stopped motor, coasting or large jumps
            len = $urandom_range(2, 15);
            repeat (len) begin
                delta = $urandom_range(0, 200000);
                if ($urandom_range(0, 1) == 0) delta = -delta;
                en = 1'($urandom);
                tick(cur_count + delta, en ? 7'd0 : SP_W'($urandom_range(0, 127)), en,
                     ($urandom_range(0, 5) == 0) ? ~cur_fwd : cur_fwd);
            end
        end
    endtask

    initial begin
        int phase;
        int phase_end;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_GAIN_PROP;
        cfg_wdata   = '0;
        cycle_count = 0;
        cur_count   = '0;
        cur_fwd     = 1'b1;
        burst_left  = 0;
        ticks_sent  = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_ticks();
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_regs(12'd10, 12'd15, 12'd150, 12'd2000);
                1: program_regs(12'd0, 12'd0, 12'd0, 12'd0);
                2: program_regs(12'd255, 12'd255, 12'd4095, 12'd2047);
                3: program_regs(12'hfff, 12'hf00, 12'd1, 12'hfff);
                4: program_regs(12'd255, 12'd0, 12'd4095, 12'd1);
                5: program_regs(12'd0, 12'd255, 12'd20, 12'd1500);
                default: program_regs(CFG_W'($urandom), CFG_W'($urandom),
                                      CFG_W'($urandom), CFG_W'($urandom));
            endcase
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end) run_segment();
            drain();
        end

        if (fail_count == 0 && results_pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pimsc_pkg.sv
design/pimsc_state_calc.sv
design/pimsc_duty_calc.sv
design/pi_motor_speed_controller.sv
verif/pimsc_checker.sv
verif/tb_top.sv
